// File: rtl/att_pkg.sv
// Package for the aging target table: shared field widths, register indexes,
// per-cell control, stored entry and argmax candidate types.
// No dependencies.
package att_pkg;

	localparam int KEY_MAX_W  = 64;
	localparam int HOLD_W     = 8;
	localparam int FREQ_W     = 16;
	localparam int AMP_W      = 16;
	localparam int SLOT_MAX_W = 8;
	localparam int CNT_MAX_W  = 9;
	localparam int OUT_CNT_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENSING_ENABLED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_ENABLE   = 2'd2;

	typedef struct packed {
		logic                    wr;
		logic                    age;
		logic                    clr;
		logic                    scan_clr;
		logic                    any_match;
		logic [KEY_MAX_W-1:0]    key;
		logic [HOLD_W-1:0]       hold;
		logic [FREQ_W-1:0]       detect_freq;
		logic [FREQ_W-1:0]       actual_freq;
		logic signed [AMP_W-1:0] amplitude;
	} cell_ctl_t;

	typedef struct packed {
		logic [KEY_MAX_W-1:0]    key;
		logic [FREQ_W-1:0]       detect_freq;
		logic [FREQ_W-1:0]       actual_freq;
		logic signed [AMP_W-1:0] amplitude;
	} ent_t;

	typedef struct packed {
		logic                    vld;
		logic [KEY_MAX_W-1:0]    key;
		logic signed [AMP_W-1:0] amplitude;
		logic [SLOT_MAX_W-1:0]   slot;
		logic [CNT_MAX_W-1:0]    cnt;
	} cand_t;

endpackage

// File: rtl/att_cell.sv
// One table slot: stores a target, matches keys, finds the first free slot
// along the chain and folds the argmax/count candidate handed from its neighbor.
// Depends on att_pkg.
module att_cell #(
	parameter int KEY_BITS = 64,
	parameter int SLOT     = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  att_pkg::cell_ctl_t ctl,
	input  logic              look_in,
	output logic              look_out,
	input  att_pkg::cand_t    cand_in,
	output att_pkg::cand_t    cand_out,
	output logic              match,
	output logic              vld,
	output att_pkg::ent_t     ent
);

	localparam logic [att_pkg::SLOT_MAX_W-1:0] SLOT_ID = att_pkg::SLOT_MAX_W'(SLOT);

	logic                             vld_q;
	logic [KEY_BITS-1:0]              key_q;
	logic [att_pkg::HOLD_W-1:0]       hold_q;
	logic [att_pkg::FREQ_W-1:0]       df_q;
	logic [att_pkg::FREQ_W-1:0]       af_q;
	logic signed [att_pkg::AMP_W-1:0] amp_q;
	att_pkg::cand_t                   cand_q;
	att_pkg::cand_t                   cand_nxt;
	logic [att_pkg::KEY_MAX_W-1:0]    key_ext;
	logic                             first_free;
	logic                             wr_here;
	logic                             better;

	assign key_ext    = att_pkg::KEY_MAX_W'(key_q);
	assign match      = vld_q && (key_q == ctl.key[KEY_BITS-1:0]);
	assign first_free = !vld_q && look_in;
	assign look_out   = look_in && vld_q;
	assign wr_here    = ctl.wr && (match || (first_free && !ctl.any_match));
	assign vld        = vld_q;
	assign ent        = '{key: key_ext, detect_freq: df_q, actual_freq: af_q, amplitude: amp_q};

	assign better = vld_q && (!cand_in.vld || (amp_q > cand_in.amplitude) ||
		((amp_q == cand_in.amplitude) && (key_ext < cand_in.key)));

	always_comb begin
		cand_nxt     = cand_in;
		cand_nxt.cnt = cand_in.cnt + att_pkg::CNT_MAX_W'(vld_q);
		if (better) begin
			cand_nxt.vld       = 1'b1;
			cand_nxt.key       = key_ext;
			cand_nxt.amplitude = amp_q;
			cand_nxt.slot      = SLOT_ID;
		end
	end

	assign cand_out = cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			cand_q <= '0;
		end else begin
			if (ctl.clr) begin
				vld_q <= 1'b0;
			end else if (ctl.age) begin
				if (hold_q <= att_pkg::HOLD_W'(1)) vld_q <= 1'b0;
			end else if (wr_here) begin
				vld_q <= 1'b1;
			end
			if (ctl.scan_clr) cand_q <= '0;
			else cand_q <= cand_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			key_q  <= ctl.key[KEY_BITS-1:0];
			hold_q <= ctl.hold;
			df_q   <= ctl.detect_freq;
			af_q   <= ctl.actual_freq;
			amp_q  <= ctl.amplitude;
		end else if (ctl.age && vld_q && (hold_q != '0)) begin
			hold_q <= hold_q - att_pkg::HOLD_W'(1);
		end
	end

endmodule

// File: rtl/aging_target_table_with_argmax_top.sv
// Top level of the aging target table: stream ports, configuration, batch
// sequencer and the row of att_cell slots. Depends on att_pkg and att_cell.
//
// An item that does not close a batch is taken while the sequencer is idle: key
// match over all slots is parallel. The item marked tlast starts the batch end:
// the S_AGE state ages or clears every slot, then the argmax and count candidate
// walks the row of cells, one cell per cycle, through S_SCAN, and S_DONE loads
// the result register, so a batch end occupies the input through these states
// plus any wait for a previous result still held on the output.
// The result register lets the next items
// flow while a result waits.
module aging_target_table_with_argmax_top #(
	parameter int TABLE_ENTRIES = 16,
	parameter int KEY_BITS      = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [63:0] name_key, [79:64] detect_freq, [95:80] actual_freq, [111:96] amplitude
	input  logic [111:0]                     s_axis_tdata,
	// [0] has_entry
	input  logic                             s_axis_tuser,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [4:0] target_count, [5] target_appeared, [6] target_gone, [7] best_valid,
	// [71:8] best_name_key, [87:72] best_detect_freq, [103:88] best_actual_freq,
	// [119:104] best_amplitude, [120] table_overflow, [127:121] zero
	output logic [127:0]                     m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [att_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [att_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SLOT_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_AGE  = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [SLOT_W-1:0]          scan_q;
	logic [att_pkg::HOLD_W-1:0] hold_count_q;
	logic                       sensing_q;
	logic                       select_q;
	logic                       in_batch_q;
	logic                       ovf_q;
	logic [CNT_W-1:0]           start_cnt_q;
	logic [CNT_W-1:0]           count_q;
	logic                       best_sel_q;
	logic [SLOT_W-1:0]          best_slot_q;
	logic                       out_vld_q;
	logic [127:0]               out_data_q;

	att_pkg::cell_ctl_t         ctl;
	logic [TABLE_ENTRIES:0]     look;
	att_pkg::cand_t             cand [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0]   match_v;
	logic [TABLE_ENTRIES-1:0]   vld_v;
	att_pkg::ent_t              ent_v [TABLE_ENTRIES];

	logic                       in_acc;
	logic                       wr_item;
	logic                       load_out;
	logic                       new_sel;
	logic [SLOT_W-1:0]          new_slot;
	logic [CNT_W-1:0]           n_cnt;
	att_pkg::ent_t              best_ent;
	att_pkg::cand_t             fin;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign wr_item       = in_acc && s_axis_tuser && sensing_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		ctl             = '0;
		ctl.wr          = wr_item;
		ctl.age         = (state_q == S_AGE) && sensing_q;
		ctl.clr         = (state_q == S_AGE) && !sensing_q;
		ctl.scan_clr    = (state_q == S_AGE);
		ctl.any_match   = |match_v;
		ctl.key         = s_axis_tdata[63:0];
		ctl.hold        = hold_count_q;
		ctl.detect_freq = s_axis_tdata[79:64];
		ctl.actual_freq = s_axis_tdata[95:80];
		ctl.amplitude   = s_axis_tdata[111:96];
	end

	assign look[0] = 1'b1;
	assign cand[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		att_cell #(
			.KEY_BITS (KEY_BITS),
			.SLOT     (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.look_in  (look[i]),
			.look_out (look[i+1]),
			.cand_in  (cand[i]),
			.cand_out (cand[i+1]),
			.match    (match_v[i]),
			.vld      (vld_v[i]),
			.ent      (ent_v[i])
		);
	end

	assign fin   = cand[TABLE_ENTRIES];
	assign n_cnt = fin.cnt[CNT_W-1:0];

	always_comb begin
		new_sel  = best_sel_q;
		new_slot = best_slot_q;
		if (!sensing_q) begin
			new_sel  = 1'b0;
			new_slot = '0;
		end else if (select_q) begin
			new_sel  = fin.vld;
			new_slot = fin.vld ? fin.slot[SLOT_W-1:0] : '0;
		end else if (best_sel_q && !vld_v[best_slot_q]) begin
			new_sel  = 1'b0;
			new_slot = '0;
		end
	end

	assign best_ent = ent_v[new_slot];
	assign load_out = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q <= att_pkg::HOLD_W'(5);
			sensing_q    <= 1'b1;
			select_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				att_pkg::REG_HOLD_COUNT:      hold_count_q <= cfg_data;
				att_pkg::REG_SENSING_ENABLED: sensing_q    <= cfg_data[0];
				att_pkg::REG_SELECT_ENABLE:   select_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			in_batch_q  <= 1'b0;
			ovf_q       <= 1'b0;
			start_cnt_q <= '0;
			count_q     <= '0;
			best_sel_q  <= 1'b0;
			best_slot_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (load_out) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!in_batch_q) start_cnt_q <= count_q;
						ovf_q <= (in_batch_q && ovf_q) ||
							(wr_item && !(|match_v) && look[TABLE_ENTRIES]);
						in_batch_q <= !s_axis_tlast;
						if (s_axis_tlast) state_q <= S_AGE;
					end
				end
				S_AGE: begin
					scan_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					scan_q <= scan_q + SLOT_W'(1);
					if (scan_q == SLOT_W'(TABLE_ENTRIES - 1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						count_q     <= n_cnt;
						best_sel_q  <= new_sel;
						best_slot_q <= new_slot;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {7'd0, ovf_q,
				(new_sel ? {best_ent.amplitude, best_ent.actual_freq,
					best_ent.detect_freq, best_ent.key} : 112'd0),
				new_sel,
				(start_cnt_q != '0) && (n_cnt == '0),
				(start_cnt_q == '0) && (n_cnt != '0),
				att_pkg::OUT_CNT_W'(n_cnt)};
		end
	end

endmodule

// File: rtl/att_checker.sv
// Port-level checker for the aging target table, bound to the top level.
// Depends on aging_target_table_with_argmax_top port names only.
module att_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         s_axis_tlast,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result transaction changed while stalled");

	a_batch_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("input taken right after batch end");

	a_no_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[7]) |-> (m_axis_tdata[119:8] == '0))
		else $error("best fields not zero without selection");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[5] && m_axis_tdata[6]))
		else $error("appeared and gone both set");

endmodule

bind aging_target_table_with_argmax_top att_checker u_att_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb_top.sv
// Testbench for aging_target_table_with_argmax_top: stream stimulus, config writes,
// a scoreboard that predicts each batch-end report from a local model of the table.
// Depends on att_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int SLOTS      = 16;
	localparam int IDLE_LIMIT = 3000;

	typedef struct {
		logic [4:0]         count;
		logic               appeared;
		logic               gone;
		logic               best_vld;
		logic [63:0]        best_key;
		logic [15:0]        best_df;
		logic [15:0]        best_af;
		logic signed [15:0] best_amp;
		logic               overflow;
	} report_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [att_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [att_pkg::CFG_DATA_W-1:0] cfg_data;

	aging_target_table_with_argmax_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// table model
	logic               tgt_valid [SLOTS];
	logic [63:0]        tgt_key   [SLOTS];
	logic [7:0]         tgt_hold  [SLOTS];
	logic [15:0]        tgt_df    [SLOTS];
	logic [15:0]        tgt_af    [SLOTS];
	logic signed [15:0] tgt_amp   [SLOTS];
	logic [7:0]  hold_reload;
	logic        sensing_on;
	logic        select_on;
	int          start_count;
	logic        batch_open;
	logic        dropped_new;
	logic        best_held;
	int          best_idx;

	report_t reports_due[$];
	int      errors;
	int      idle_cycles;
	bit      tx_no_gap;
	bit      rx_no_gap;
	bit      rx_hold_req;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int held_targets();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (tgt_valid[i]) n++;
		return n;
	endfunction

	task automatic write_target(logic [63:0] key, logic [15:0] df, logic [15:0] af,
		logic signed [15:0] amp);
		int free_idx;
		free_idx = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (tgt_valid[i] && tgt_key[i] == key) begin
				tgt_df[i] = df;
				tgt_af[i] = af;
				tgt_amp[i] = amp;
				tgt_hold[i] = hold_reload;
				return;
			end
			if (!tgt_valid[i] && free_idx < 0)
				free_idx = i;
		end
		if (free_idx < 0) begin
			dropped_new = 1'b1;
			return;
		end
		tgt_valid[free_idx] = 1'b1;
		tgt_key[free_idx] = key;
		tgt_df[free_idx] = df;
		tgt_af[free_idx] = af;
		tgt_amp[free_idx] = amp;
		tgt_hold[free_idx] = hold_reload;
	endtask

	task automatic predict_item(bit has, logic [63:0] key, logic [15:0] df, logic [15:0] af,
		logic signed [15:0] amp, bit last);
		report_t r;
		int n;
		bit found;
		int pick;
		if (!batch_open) begin
			start_count = held_targets();
			dropped_new = 1'b0;
			batch_open = 1'b1;
		end
		if (has && sensing_on)
			write_target(key, df, af, amp);
		if (!last)
			return;
		batch_open = 1'b0;
		if (sensing_on) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!tgt_valid[i])
					continue;
				if (tgt_hold[i] > 0)
					tgt_hold[i]--;
				if (tgt_hold[i] == 0)
					tgt_valid[i] = 1'b0;
			end
			if (select_on) begin
				found = 0;
				pick = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (!tgt_valid[i])
						continue;
					if (!found || tgt_amp[i] > tgt_amp[pick] ||
						(tgt_amp[i] == tgt_amp[pick] && tgt_key[i] < tgt_key[pick])) begin
						pick = i;
						found = 1;
					end
				end
				best_held = found;
				best_idx = found ? pick : 0;
			end else if (best_held && !tgt_valid[best_idx]) begin
				best_held = 1'b0;
				best_idx = 0;
			end
		end else begin
			for (int i = 0; i < SLOTS; i++)
				tgt_valid[i] = 1'b0;
			best_held = 1'b0;
			best_idx = 0;
		end
		n = held_targets();
		r.count = n[4:0];
		r.appeared = (start_count == 0 && n > 0);
		r.gone = (start_count > 0 && n == 0);
		r.best_vld = best_held;
		r.best_key = best_held ? tgt_key[best_idx] : '0;
		r.best_df = best_held ? tgt_df[best_idx] : '0;
		r.best_af = best_held ? tgt_af[best_idx] : '0;
		r.best_amp = best_held ? tgt_amp[best_idx] : '0;
		r.overflow = dropped_new;
		reports_due.push_back(r);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// check each output transaction against the oldest predicted report
	always @(posedge clk) begin
		report_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (reports_due.size() == 0) begin
				report_mismatch("unexpected report", m_axis_tdata[63:0], 64'd0);
			end else begin
				r = reports_due.pop_front();
				if (m_axis_tdata[4:0] !== r.count)
					report_mismatch("target_count", m_axis_tdata[4:0], r.count);
				if (m_axis_tdata[5] !== r.appeared)
					report_mismatch("target_appeared", m_axis_tdata[5], r.appeared);
				if (m_axis_tdata[6] !== r.gone)
					report_mismatch("target_gone", m_axis_tdata[6], r.gone);
				if (m_axis_tdata[7] !== r.best_vld)
					report_mismatch("best_valid", m_axis_tdata[7], r.best_vld);
				if (m_axis_tdata[71:8] !== r.best_key)
					report_mismatch("best_name_key", m_axis_tdata[71:8], r.best_key);
				if (m_axis_tdata[87:72] !== r.best_df)
					report_mismatch("best_detect_freq", m_axis_tdata[87:72], r.best_df);
				if (m_axis_tdata[103:88] !== r.best_af)
					report_mismatch("best_actual_freq", m_axis_tdata[103:88], r.best_af);
				if (m_axis_tdata[119:104] !== r.best_amp)
					report_mismatch("best_amplitude", m_axis_tdata[119:104], r.best_amp);
				if (m_axis_tdata[120] !== r.overflow)
					report_mismatch("table_overflow", m_axis_tdata[120], r.overflow);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold when requested
	initial begin
		int wait_n;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
				rx_hold_req = 0;
			end
			wait_n = rx_no_gap ? 0 : $urandom_range(0, 13);
			if (wait_n > 0) begin
				m_axis_tready = 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_item(bit has, logic [63:0] key, logic [15:0] df, logic [15:0] af,
		logic signed [15:0] amp, bit last);
		int gap;
		gap = tx_no_gap ? 0 : $urandom_range(0, 13);
		repeat (gap) @(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {amp, af, df, key};
		s_axis_tuser = has;
		s_axis_tlast = last;
		do @(posedge clk); while (!s_axis_tready);
		predict_item(has, key, df, af, amp, last);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 112'($urandom);
	endtask

	task automatic drain_reports();
		wait (reports_due.size() == 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [att_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
		drain_reports();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			att_pkg::REG_HOLD_COUNT:      hold_reload = value;
			att_pkg::REG_SENSING_ENABLED: sensing_on = value[0];
			att_pkg::REG_SELECT_ENABLE:   select_on = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [63:0] pool_key(int k);
		return {32'hA5C3_0000 | k, 32'h0F0F_0000 | k};
	endfunction

	task automatic test_extremes();
		send_item(1, 64'h0, 16'h0000, 16'h0000, -16'sd32768, 0);
		send_item(1, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'sd32767, 1);
		send_item(1, 64'h0, 16'h1234, 16'hFFFF, 16'sd32767, 1);
		send_item(0, 64'h5555_AAAA_5555_AAAA, 16'hAAAA, 16'h5555, 16'sh5555, 1);
		send_item(1, 64'hFFFF_FFFF_FFFF_FFFF, 16'h00FF, 16'h0001, 16'sd100, 0);
		send_item(1, 64'h7, 16'h00FF, 16'h0002, 16'sd100, 1);
		repeat (6)
			send_item(0, 64'h0, 16'h0, 16'h0, 16'sd0, 1);
	endtask

	task automatic test_table_full();
		write_reg(att_pkg::REG_HOLD_COUNT, 8'd255);
		for (int k = 0; k < 18; k++)
			send_item(1, pool_key(k), 16'(k), 16'(16'h100 + k), -16'sd5, k == 17);
		send_item(1, pool_key(3), 16'h9, 16'h9, 16'sd9, 1);
		write_reg(att_pkg::REG_SENSING_ENABLED, 8'd0);
		send_item(1, pool_key(40), 16'h1, 16'h1, 16'sd1, 1);
		send_item(0, 64'h0, 16'h0, 16'h0, 16'sd0, 1);
		write_reg(att_pkg::REG_SENSING_ENABLED, 8'd1);
	endtask

	task automatic test_select_and_hold();
		write_reg(att_pkg::REG_HOLD_COUNT, 8'd2);
		send_item(1, pool_key(1), 16'h10, 16'h11, 16'sd50, 0);
		send_item(1, pool_key(2), 16'h20, 16'h21, 16'sd10, 1);
		write_reg(att_pkg::REG_SELECT_ENABLE, 8'd0);
		send_item(1, pool_key(2), 16'h22, 16'h23, 16'sd90, 1);
		send_item(0, 64'h0, 16'h0, 16'h0, 16'sd0, 1);
		send_item(0, 64'h0, 16'h0, 16'h0, 16'sd0, 1);
		write_reg(att_pkg::REG_HOLD_COUNT, 8'd0);
		send_item(1, pool_key(4), 16'h4, 16'h4, 16'sd4, 1);
		write_reg(att_pkg::REG_SELECT_ENABLE, 8'd1);
		send_item(1, pool_key(5), 16'h5, 16'h5, 16'sd5, 1);
		write_reg(att_pkg::REG_HOLD_COUNT, 8'd1);
		send_item(1, pool_key(6), 16'h6, 16'h6, 16'sd6, 1);
	endtask

	task automatic test_backpressure();
		write_reg(att_pkg::REG_HOLD_COUNT, 8'd3);
		rx_hold_req = 1;
		tx_no_gap = 1;
		for (int k = 0; k < 30; k++)
			send_item(1, pool_key(k % 8), 16'(k), 16'(k), 16'($urandom), (k % 3) == 2);
		tx_no_gap = 0;
		drain_reports();
	endtask

	task automatic random_batches(int items);
		int sent;
		int len;
		logic [63:0] key;
		logic signed [15:0] amp;
		sent = 0;
		while (sent < items) begin
			len = $urandom_range(1, 6);
			for (int j = 0; j < len; j++) begin
				key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
					: pool_key($urandom_range(0, 21));
				amp = ($urandom_range(0, 2) == 0) ? 16'(25 * $urandom_range(0, 3))
					: 16'($urandom);
				send_item($urandom_range(0, 9) != 0, key, 16'($urandom), 16'($urandom),
					amp, j == len - 1);
				sent++;
			end
		end
	endtask

	task automatic test_random();
		logic [7:0] holds [4];
		holds = '{8'd1, 8'd4, 8'd255, 8'd0};
		for (int p = 0; p < 7; p++) begin
			tx_no_gap = (p == 2);
			rx_no_gap = (p == 3);
			write_reg(att_pkg::REG_HOLD_COUNT,
				(p < 4) ? holds[p] : 8'($urandom_range(1, 12)));
			write_reg(att_pkg::REG_SENSING_ENABLED, 8'(p != 5));
			write_reg(att_pkg::REG_SELECT_ENABLE, 8'(p != 4));
			random_batches(90);
		end
		tx_no_gap = 0;
		rx_no_gap = 0;
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		tx_no_gap = 0;
		rx_no_gap = 0;
		rx_hold_req = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = att_pkg::REG_HOLD_COUNT;
		cfg_data = '0;
		for (int i = 0; i < SLOTS; i++)
			tgt_valid[i] = 1'b0;
		hold_reload = 8'd5;
		sensing_on = 1'b1;
		select_on = 1'b1;
		start_count = 0;
		batch_open = 1'b0;
		dropped_new = 1'b0;
		best_held = 1'b0;
		best_idx = 0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_table_full();
		test_select_and_hold();
		test_backpressure();
		test_random();

		drain_reports();
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
rtl/att_pkg.sv
rtl/att_cell.sv
rtl/aging_target_table_with_argmax_top.sv
rtl/att_checker.sv
sim/tb_top.sv
